@@ sv/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	// Data sizes
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W      = $clog2(MAX_DIGITS);
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int RECIP_DEPTH = 37;

	// Radix limits and codes
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

	// Character codes
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 8'h2d;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = DIGIT_W'(9);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN     = DIGIT_W'(10);

	typedef logic [VALUE_WIDTH-1:0] word_t;

	// floor(2^W / r) for each radix; underestimates the quotient by at most one
	localparam logic [VALUE_WIDTH:0] POW = (VALUE_WIDTH + 1)'(1) << VALUE_WIDTH;
	localparam word_t RECIP [RECIP_DEPTH] = '{
		'0, '0,
		word_t'(POW / 2),  word_t'(POW / 3),  word_t'(POW / 4),  word_t'(POW / 5),
		word_t'(POW / 6),  word_t'(POW / 7),  word_t'(POW / 8),  word_t'(POW / 9),
		word_t'(POW / 10), word_t'(POW / 11), word_t'(POW / 12), word_t'(POW / 13),
		word_t'(POW / 14), word_t'(POW / 15), word_t'(POW / 16), word_t'(POW / 17),
		word_t'(POW / 18), word_t'(POW / 19), word_t'(POW / 20), word_t'(POW / 21),
		word_t'(POW / 22), word_t'(POW / 23), word_t'(POW / 24), word_t'(POW / 25),
		word_t'(POW / 26), word_t'(POW / 27), word_t'(POW / 28), word_t'(POW / 29),
		word_t'(POW / 30), word_t'(POW / 31), word_t'(POW / 32), word_t'(POW / 33),
		word_t'(POW / 34), word_t'(POW / 35), word_t'(POW / 36)
	};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BACK,
		ST_FIX,
		ST_SIGN,
		ST_READ,
		ST_SHOW
	} state_t;

	// Digit value to ASCII
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d > DIGIT_MAX_DEC)
			return CHAR_LOWER_A + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
		else
			return CHAR_ZERO + dx;
	endfunction

endpackage

@@ sv/itoa_if.sv @@
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------

// Input channel: one signed value per item
interface itoa_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [itoa_pkg::VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// Output channel: one character per item
interface itoa_out_if;
	logic                          valid;
	logic                          ready;
	logic [itoa_pkg::CHAR_W-1:0]   character;
	logic                          last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink (input valid, input character, input last_char, output ready);
endinterface

@@ sv/integer_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts an integer to ASCII digits in a programmable radix (signed in radix ten).
// Each digit is found on the shared multiplier: multiply by the reciprocal,
// multiply back by the radix, then correct. Then the sign and the characters
// are emitted, most significant first, each held until the output is ready.
// A new value is accepted only when idle, after the last character of the last.
// Reset: arst_n clears the sequencer, count and sign; radix returns to ten.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itoa_pkg::RADIX_W-1:0]   cfg_wdata,
	itoa_in_if.sink                        in_item,
	itoa_out_if.source                     out_item
);

	localparam int W  = itoa_pkg::VALUE_WIDTH;
	localparam int RW = itoa_pkg::RADIX_W;

	itoa_pkg::state_t                state_q, state_d;
	logic [RW-1:0]                   radix_q;
	logic [itoa_pkg::CNT_W-1:0]      cnt_q;
	logic                            neg_q;

	logic [W-1:0]                    rq_q;
	logic [RW-1:0]                   r_q;
	logic [W-1:0]                    m_q;
	logic [2*W-1:0]                  prod_q;
	logic [W-1:0]                    hi_q;
	logic [itoa_pkg::DIGIT_W-1:0]    rd_q;
	logic [itoa_pkg::DIGIT_W-1:0]    mem [itoa_pkg::MAX_DIGITS];

	logic                            accept;
	logic [W-1:0]                    v_in;
	logic [RW-1:0]                   r_in;
	logic                            neg_in;
	logic [W-1:0]                    mul_a, mul_b;
	logic [2*W-1:0]                  mul_p;
	logic [W-1:0]                    rem;
	logic [W-1:0]                    r_ext;
	logic                            rem_ge;
	logic [itoa_pkg::DIGIT_W-1:0]    digit;
	logic [W-1:0]                    q_next;
	logic [itoa_pkg::CNT_W-1:0]      cnt_inc;
	logic                            more;
	logic [itoa_pkg::ADDR_W-1:0]     rd_addr;

	assign accept = in_item.valid && in_item.ready;

	// Clamp radix and fold sign at the start of a conversion
	always_comb begin
		v_in = W'(in_item.value);
		if (radix_q < itoa_pkg::RADIX_MIN)
			r_in = itoa_pkg::RADIX_MIN;
		else if (radix_q > itoa_pkg::RADIX_MAX)
			r_in = itoa_pkg::RADIX_MAX;
		else
			r_in = radix_q;
		neg_in = v_in[W-1] && (r_in == itoa_pkg::RADIX_DEC);
	end

	// Shared multiplier: quotient estimate, then estimate times radix
	always_comb begin
		r_ext = {{(W-RW){1'b0}}, r_q};
		mul_a = (state_q == itoa_pkg::ST_MUL) ? rq_q : prod_q[2*W-1:W];
		mul_b = (state_q == itoa_pkg::ST_MUL) ? m_q : r_ext;
		mul_p = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
	end

	// Remainder correction; the estimate is low by at most one
	always_comb begin
		rem     = rq_q - prod_q[W-1:0];
		rem_ge  = rem >= r_ext;
		digit   = rem_ge ? itoa_pkg::DIGIT_W'(rem - r_ext) : itoa_pkg::DIGIT_W'(rem);
		q_next  = rem_ge ? hi_q + W'(1) : hi_q;
		cnt_inc = cnt_q + itoa_pkg::CNT_W'(1);
		more    = (q_next != '0) && (cnt_inc < itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS));
		rd_addr = itoa_pkg::ADDR_W'(cnt_q - itoa_pkg::CNT_W'(1));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: if (in_item.valid) state_d = itoa_pkg::ST_MUL;
			itoa_pkg::ST_MUL:  state_d = itoa_pkg::ST_BACK;
			itoa_pkg::ST_BACK: state_d = itoa_pkg::ST_FIX;
			itoa_pkg::ST_FIX: begin
				if (more)
					state_d = itoa_pkg::ST_MUL;
				else if (neg_q)
					state_d = itoa_pkg::ST_SIGN;
				else
					state_d = itoa_pkg::ST_READ;
			end
			itoa_pkg::ST_SIGN: if (out_item.ready) state_d = itoa_pkg::ST_READ;
			itoa_pkg::ST_READ: state_d = itoa_pkg::ST_SHOW;
			itoa_pkg::ST_SHOW: begin
				if (out_item.ready)
					state_d = (cnt_q == '0) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
			end
			default: state_d = itoa_pkg::ST_IDLE;
		endcase
	end

	// Handshake and output item
	always_comb begin
		in_item.ready      = 1'b0;
		out_item.valid     = 1'b0;
		out_item.character = itoa_pkg::digit_char(rd_q);
		out_item.last_char = 1'b0;
		unique case (state_q)
			itoa_pkg::ST_IDLE: in_item.ready = 1'b1;
			itoa_pkg::ST_SIGN: begin
				out_item.valid     = 1'b1;
				out_item.character = itoa_pkg::CHAR_MINUS;
			end
			itoa_pkg::ST_SHOW: begin
				out_item.valid     = 1'b1;
				out_item.last_char = (cnt_q == '0);
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
			radix_q <= itoa_pkg::RADIX_RESET;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				radix_q <= cfg_wdata;
			if (accept) begin
				cnt_q <= '0;
				neg_q <= neg_in;
			end else if (state_q == itoa_pkg::ST_FIX) begin
				cnt_q <= cnt_inc;
			end else if (state_q == itoa_pkg::ST_READ) begin
				cnt_q <= cnt_q - itoa_pkg::CNT_W'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rq_q <= neg_in ? (W'(0) - v_in) : v_in;
			r_q  <= r_in;
			m_q  <= itoa_pkg::RECIP[r_in];
		end
		if (state_q == itoa_pkg::ST_MUL || state_q == itoa_pkg::ST_BACK)
			prod_q <= mul_p;
		if (state_q == itoa_pkg::ST_BACK)
			hi_q <= prod_q[2*W-1:W];
		if (state_q == itoa_pkg::ST_FIX)
			rq_q <= q_next;
	end

	// Digit store, least significant digit first
	always_ff @(posedge clk) begin
		if (state_q == itoa_pkg::ST_FIX)
			mem[cnt_q[itoa_pkg::ADDR_W-1:0]] <= digit;
		if (state_q == itoa_pkg::ST_READ)
			rd_q <= mem[rd_addr];
	end

endmodule
